// ----- src/job_slot_table_defines.svh -----
// assertion macros used by the property checker in src/jst_checker.sv
`ifndef JOB_SLOT_TABLE_DEFINES_SVH
`define JOB_SLOT_TABLE_DEFINES_SVH

// same-cycle implication, checked on every edge out of reset
`define JST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every edge out of reset
`define JST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/jst_pkg.sv -----
package jst_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int MAX_RESULTS = 16;

  localparam int REQ_W   = 3;
  localparam int PID_W   = 22;
  localparam int STATE_W = 2;
  localparam int JID_W   = 8;
  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int CNT_W   = $clog2(MAX_RESULTS);

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_LOOKUP = 3'd2,
    REQ_STOP   = 3'd3,
    REQ_LIST   = 3'd4
  } req_t;

  // job states
  typedef enum logic [STATE_W-1:0] {
    JS_UNDEF = 2'd0,
    JS_FG    = 2'd1,
    JS_BG    = 2'd2,
    JS_STOP  = 2'd3
  } job_state_t;

  // what the output register loads
  typedef enum logic [2:0] {
    OSEL_NONE,
    OSEL_FAIL,
    OSEL_ADD,
    OSEL_SLOT,
    OSEL_STOP,
    OSEL_PEND_MORE,
    OSEL_PEND_LAST
  } osel_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SCAN,
    CS_LIST,
    CS_MAX,
    CS_FLUSH
  } ctl_state_t;

  typedef struct packed {
    logic  load;
    logic  idx_clr;
    logic  idx_inc;
    logic  add_wr;
    logic  rm_wr;
    logic  stop_wr;
    logic  max_upd;
    logic  max_done;
    logic  pend_take;
    osel_t out_sel;
  } jst_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_add;
    logic is_remove;
    logic is_list;
    logic is_stop;
    logic slot_free;
    logic slot_match;
    logic slot_fg;
    logic idx_last;
    logic cnt_last;
    logic pend_valid;
    logic out_free;
  } jst_sts_t;

endpackage

// ----- src/jst_if.sv -----
interface jst_req_if import jst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [PID_W-1:0]   proc_id;
  logic [STATE_W-1:0] new_state;

  modport source (output valid, req_type, proc_id, new_state, input ready);
  modport sink   (input valid, req_type, proc_id, new_state, output ready);
endinterface

interface jst_rsp_if import jst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [JID_W-1:0]   job_id;
  logic [STATE_W-1:0] job_state;
  logic [PID_W-1:0]   found_pid;
  logic               last;

  modport source (output valid, ok, job_id, job_state, found_pid, last, input ready);
  modport sink   (input valid, ok, job_id, job_state, found_pid, last, output ready);
endinterface

// ----- src/jst_datapath.sv -----
module jst_datapath import jst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [PID_W-1:0]   in_proc_id,
  input  logic [STATE_W-1:0] in_new_state,
  input  jst_cmd_t           cmd,
  output jst_sts_t           sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_ok,
  output logic [JID_W-1:0]   out_job_id,
  output logic [STATE_W-1:0] out_job_state,
  output logic [PID_W-1:0]   out_found_pid,
  output logic               out_last
);

  logic [PID_W-1:0]   slot_pid_r [SLOT_COUNT];
  logic [JID_W-1:0]   slot_jid_r [SLOT_COUNT];
  logic [STATE_W-1:0] slot_st_r  [SLOT_COUNT];
  logic [JID_W-1:0]   next_id_r;

  logic [REQ_W-1:0]   req_type_r;
  logic [PID_W-1:0]   req_pid_r;
  logic [STATE_W-1:0] req_nst_r;

  logic [IDX_W-1:0]   idx_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [JID_W-1:0]   max_r;
  logic               pend_valid_r;
  logic [JID_W-1:0]   pend_jid_r;
  logic [PID_W-1:0]   pend_pid_r;

  logic               out_valid_r;
  logic               out_ok_r;
  logic [JID_W-1:0]   out_jid_r;
  logic [STATE_W-1:0] out_st_r;
  logic [PID_W-1:0]   out_pid_r;
  logic               out_last_r;

  logic [PID_W-1:0]   cur_pid;
  logic [JID_W-1:0]   cur_jid;
  logic [STATE_W-1:0] cur_st;
  logic [JID_W-1:0]   add_bump;
  logic [JID_W-1:0]   add_next;
  logic [JID_W-1:0]   max_nxt;
  logic [JID_W-1:0]   max_bump;

  assign cur_pid = slot_pid_r[idx_r];
  assign cur_jid = slot_jid_r[idx_r];
  assign cur_st  = slot_st_r[idx_r];

  // next id after an add: saturate, then wrap past the slot count
  assign add_bump = (next_id_r == '1) ? next_id_r : next_id_r + JID_W'(1);
  assign add_next = (add_bump > JID_W'(SLOT_COUNT)) ? JID_W'(1) : add_bump;

  // running maximum of the held job ids, saturating bump at the end
  assign max_nxt  = (cur_jid > max_r) ? cur_jid : max_r;
  assign max_bump = (max_nxt == '1) ? max_nxt : max_nxt + JID_W'(1);

  always_comb begin
    sts.is_add     = (req_type_r == REQ_ADD);
    sts.is_remove  = (req_type_r == REQ_REMOVE);
    sts.is_list    = (req_type_r == REQ_LIST);
    sts.is_stop    = (req_type_r == REQ_STOP);
    sts.bad        = (req_type_r > REQ_LIST) || (!sts.is_list && req_pid_r == '0);
    sts.slot_free  = (cur_pid == '0);
    sts.slot_match = (cur_pid == req_pid_r);
    sts.slot_fg    = (cur_st == JS_FG);
    sts.idx_last   = (idx_r == IDX_W'(SLOT_COUNT - 1));
    sts.cnt_last   = (cnt_r == CNT_W'(MAX_RESULTS - 1));
    sts.pend_valid = pend_valid_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // slot table and next id
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_pid_r[i] <= '0;
        slot_jid_r[i] <= '0;
        slot_st_r[i]  <= JS_UNDEF;
      end
      next_id_r <= JID_W'(1);
    end else begin
      if (cmd.add_wr) begin
        slot_pid_r[idx_r] <= req_pid_r;
        slot_jid_r[idx_r] <= next_id_r;
        slot_st_r[idx_r]  <= req_nst_r;
        next_id_r         <= add_next;
      end
      if (cmd.rm_wr) begin
        slot_pid_r[idx_r] <= '0;
        slot_jid_r[idx_r] <= '0;
        slot_st_r[idx_r]  <= JS_UNDEF;
      end
      if (cmd.stop_wr) begin
        slot_st_r[idx_r] <= JS_STOP;
      end
      if (cmd.max_done) begin
        next_id_r <= max_bump;
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      req_pid_r  <= in_proc_id;
      req_nst_r  <= in_new_state;
    end
  end

  // scan index, max and listing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      cnt_r        <= '0;
      max_r        <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.load || cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.load) begin
        cnt_r        <= '0;
        max_r        <= '0;
        pend_valid_r <= 1'b0;
      end else begin
        if (cmd.max_upd) begin
          max_r <= max_nxt;
        end
        if (cmd.pend_take) begin
          pend_valid_r <= 1'b1;
          cnt_r        <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_take) begin
      pend_jid_r <= cur_jid;
      pend_pid_r <= cur_pid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_sel != OSEL_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.out_sel)
      OSEL_NONE: begin
      end
      OSEL_FAIL: begin
        out_ok_r   <= 1'b0;
        out_jid_r  <= '0;
        out_st_r   <= JS_UNDEF;
        out_pid_r  <= '0;
        out_last_r <= 1'b1;
      end
      OSEL_ADD: begin
        out_ok_r   <= 1'b1;
        out_jid_r  <= next_id_r;
        out_st_r   <= req_nst_r;
        out_pid_r  <= req_pid_r;
        out_last_r <= 1'b1;
      end
      OSEL_SLOT: begin
        out_ok_r   <= 1'b1;
        out_jid_r  <= cur_jid;
        out_st_r   <= cur_st;
        out_pid_r  <= req_pid_r;
        out_last_r <= 1'b1;
      end
      OSEL_STOP: begin
        out_ok_r   <= 1'b1;
        out_jid_r  <= cur_jid;
        out_st_r   <= JS_STOP;
        out_pid_r  <= req_pid_r;
        out_last_r <= 1'b1;
      end
      OSEL_PEND_MORE: begin
        out_ok_r   <= 1'b1;
        out_jid_r  <= pend_jid_r;
        out_st_r   <= JS_FG;
        out_pid_r  <= pend_pid_r;
        out_last_r <= 1'b0;
      end
      OSEL_PEND_LAST: begin
        out_ok_r   <= 1'b1;
        out_jid_r  <= pend_jid_r;
        out_st_r   <= JS_FG;
        out_pid_r  <= pend_pid_r;
        out_last_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_job_id    = out_jid_r;
  assign out_job_state = out_st_r;
  assign out_found_pid = out_pid_r;
  assign out_last      = out_last_r;

endmodule

// ----- src/jst_ctrl.sv -----
module jst_ctrl import jst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  jst_sts_t sts,
  output jst_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign hit = sts.is_add ? sts.slot_free : sts.slot_match;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.out_sel = OSEL_NONE;
    in_ready    = 1'b0;

    unique case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = CS_SCAN;
        end
      end

      // single-result requests; also dispatches a listing
      CS_SCAN: begin
        if (sts.bad) begin
          if (sts.out_free) begin
            cmd.out_sel = OSEL_FAIL;
            state_nxt   = CS_IDLE;
          end
        end else if (sts.is_list) begin
          state_nxt = CS_LIST;
        end else if (hit) begin
          if (sts.out_free) begin
            state_nxt = CS_IDLE;
            priority if (sts.is_add) begin
              cmd.add_wr  = 1'b1;
              cmd.out_sel = OSEL_ADD;
            end else if (sts.is_remove) begin
              cmd.rm_wr   = 1'b1;
              cmd.idx_clr = 1'b1;
              cmd.out_sel = OSEL_SLOT;
              state_nxt   = CS_MAX;
            end else if (sts.is_stop) begin
              // mark stopped rewrites the state and reports it as stopped
              cmd.stop_wr = 1'b1;
              cmd.out_sel = OSEL_STOP;
            end else begin
              cmd.out_sel = OSEL_SLOT;
            end
          end
        end else if (sts.idx_last) begin
          if (sts.out_free) begin
            cmd.out_sel = OSEL_FAIL;
            state_nxt   = CS_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end

      CS_LIST: begin
        if (sts.slot_fg) begin
          if (!sts.pend_valid || sts.out_free) begin
            if (sts.pend_valid) begin
              cmd.out_sel = OSEL_PEND_MORE;
            end
            cmd.pend_take = 1'b1;
            if (sts.cnt_last || sts.idx_last) begin
              state_nxt = CS_FLUSH;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
        end else if (sts.idx_last) begin
          state_nxt = CS_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end

      CS_FLUSH: begin
        if (sts.out_free) begin
          cmd.out_sel = sts.pend_valid ? OSEL_PEND_LAST : OSEL_FAIL;
          state_nxt   = CS_IDLE;
        end
      end

      CS_MAX: begin
        cmd.max_upd = 1'b1;
        if (sts.idx_last) begin
          cmd.max_done = 1'b1;
          state_nxt    = CS_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end

      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

// ----- src/job_slot_table.sv -----
// job_slot_table: a table of SLOT_COUNT job slots keyed by process id. Each
// request (add, remove, lookup, mark stopped, list foreground) is taken only
// while the block is idle and is worked by one shared compare unit that
// reads one slot per cycle, so the work follows the slot walk: add, lookup
// and mark stopped end at the first free or matching slot, or with a
// not-found result after the last slot; remove adds a second full walk of
// the slots to rebuild the next job id from the largest id still held;
// list foreground walks all slots and gives one result per foreground
// slot, the final one marked last, or a single not-found result. A result
// waits in the output register while the table work goes on; the walk
// stalls only when a new result is ready and the previous one has not
// yet been taken.
module job_slot_table import jst_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  jst_req_if.sink   in_req,
  jst_rsp_if.source out_rsp
);

  // command and status between the sequencer and the table datapath
  jst_cmd_t cmd;
  jst_sts_t sts;

  // sequencer: one slot per cycle unless a waiting result stalls it, one request at a time
  jst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot table, request latch, scan index, listing buffer, result register
  jst_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_req.req_type),
    .in_proc_id    (in_req.proc_id),
    .in_new_state  (in_req.new_state),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_rsp.ready),
    .out_valid     (out_rsp.valid),
    .out_ok        (out_rsp.ok),
    .out_job_id    (out_rsp.job_id),
    .out_job_state (out_rsp.job_state),
    .out_found_pid (out_rsp.found_pid),
    .out_last      (out_rsp.last)
  );

endmodule

// ----- src/jst_checker.sv -----
`include "job_slot_table_defines.svh"

module jst_prop_checker import jst_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_ok,
  input logic [JID_W-1:0]   out_job_id,
  input logic [STATE_W-1:0] out_job_state,
  input logic [PID_W-1:0]   out_found_pid,
  input logic               out_last
);

  logic                             stall;
  logic [JID_W+STATE_W+PID_W+1:0]   out_bits;
  logic                             fail_shape;
  logic                             ids_set;

  assign stall      = out_valid && !out_ready;
  assign out_bits   = {out_ok, out_job_id, out_job_state, out_found_pid, out_last};
  assign fail_shape = (out_job_id == '0) && (out_job_state == JS_UNDEF)
                      && (out_found_pid == '0) && out_last;
  assign ids_set    = (out_job_id != '0) && (out_found_pid != '0);

  // a stalled result holds
  `JST_ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(out_bits), "stalled result moved")

  // not-found results carry zeros and close the request
  `JST_ASSERT_SAME(a_fail_shape, out_valid && !out_ok, fail_shape, "malformed not-found result")

  // a found entry always has a job id and a process id
  `JST_ASSERT_SAME(a_ok_ids, out_valid && out_ok, ids_set, "found entry without ids")

  // one request at a time
  `JST_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind job_slot_table jst_prop_checker u_jst_prop_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .out_ok        (out_rsp.ok),
  .out_job_id    (out_rsp.job_id),
  .out_job_state (out_rsp.job_state),
  .out_found_pid (out_rsp.found_pid),
  .out_last      (out_rsp.last)
);

// ----- verif/jst_checker.sv -----
`timescale 1ns / 100ps
module jst_checker import jst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  jst_req_if   req,
  jst_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding,
  output int   rsp_checked
);

  typedef struct packed {
    logic               ok;
    logic [JID_W-1:0]   job_id;
    logic [STATE_W-1:0] job_state;
    logic [PID_W-1:0]   found_pid;
    logic               last;
  } job_rsp_t;

  // shadow copy of the job table
  logic [PID_W-1:0]   tbl_pid   [SLOT_COUNT];
  logic [JID_W-1:0]   tbl_jid   [SLOT_COUNT];
  logic [STATE_W-1:0] tbl_state [SLOT_COUNT];
  logic [JID_W-1:0]   tbl_next;

  job_rsp_t expected_rsp[$];
  int       mismatches = 0;
  int       checked_n = 0;

  function automatic logic [JID_W-1:0] sat_inc(input logic [JID_W-1:0] v);
    return (v == {JID_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // lowest slot holding pid, -1 if none or pid is zero
  function automatic int find_pid(input logic [PID_W-1:0] pid);
    if (pid == '0) return -1;
    for (int i = 0; i < SLOT_COUNT; i++)
      if (tbl_pid[i] == pid) return i;
    return -1;
  endfunction

  task automatic predict_request(input logic [REQ_W-1:0] kind,
                                 input logic [PID_W-1:0] pid,
                                 input logic [STATE_W-1:0] nst);
    int               s;
    int               n;
    logic [JID_W-1:0] top_jid;
    job_rsp_t         r;
    job_rsp_t         prev;
    s = -1;
    n = 0;
    top_jid = '0;
    r = '0;
    r.last = 1'b1;
    prev = '0;
    case (kind)
      REQ_ADD: begin
        if (pid != '0)
          for (int i = 0; i < SLOT_COUNT && s < 0; i++)
            if (tbl_pid[i] == '0) s = i;
        if (s >= 0) begin
          tbl_jid[s] = tbl_next;
          tbl_next = sat_inc(tbl_next);
          if (tbl_next > SLOT_COUNT) tbl_next = JID_W'(1);
          tbl_state[s] = nst;
          tbl_pid[s] = pid;
          r = '{1'b1, tbl_jid[s], nst, pid, 1'b1};
        end
        expected_rsp.push_back(r);
      end
      REQ_REMOVE: begin
        s = find_pid(pid);
        if (s >= 0) begin
          r = '{1'b1, tbl_jid[s], tbl_state[s], pid, 1'b1};
          tbl_pid[s] = '0;
          tbl_jid[s] = '0;
          tbl_state[s] = JS_UNDEF;
          for (int i = 0; i < SLOT_COUNT; i++)
            if (tbl_jid[i] > top_jid) top_jid = tbl_jid[i];
          tbl_next = sat_inc(top_jid);
        end
        expected_rsp.push_back(r);
      end
      REQ_LOOKUP: begin
        s = find_pid(pid);
        if (s >= 0) r = '{1'b1, tbl_jid[s], tbl_state[s], pid, 1'b1};
        expected_rsp.push_back(r);
      end
      REQ_STOP: begin
        s = find_pid(pid);
        if (s >= 0) begin
          tbl_state[s] = JS_STOP;
          r = '{1'b1, tbl_jid[s], JS_STOP, pid, 1'b1};
        end
        expected_rsp.push_back(r);
      end
      REQ_LIST: begin
        // hold back one entry so the final one can be marked last
        for (int i = 0; i < SLOT_COUNT && n < MAX_RESULTS; i++) begin
          if (tbl_state[i] == JS_FG) begin
            if (n > 0) expected_rsp.push_back(prev);
            prev = '{1'b1, tbl_jid[i], JS_FG, tbl_pid[i], 1'b0};
            n++;
          end
        end
        if (n > 0) begin
          prev.last = 1'b1;
          expected_rsp.push_back(prev);
        end else begin
          expected_rsp.push_back(r);
        end
      end
      default: expected_rsp.push_back(r);
    endcase
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    job_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tbl_pid[i] = '0;
        tbl_jid[i] = '0;
        tbl_state[i] = JS_UNDEF;
      end
      tbl_next = JID_W'(1);
      expected_rsp.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        checked_n++;
        if (expected_rsp.size() == 0) begin
          $display("%0t: result expected none got ok=%0b job=%0h state=%0h pid=%0h last=%0b",
                   $time, rsp.ok, rsp.job_id, rsp.job_state, rsp.found_pid, rsp.last);
          mismatches++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("ok", 32'(want.ok), 32'(rsp.ok));
          check_field("job_id", 32'(want.job_id), 32'(rsp.job_id));
          check_field("job_state", 32'(want.job_state), 32'(rsp.job_state));
          check_field("found_pid", 32'(want.found_pid), 32'(rsp.found_pid));
          check_field("last", 32'(want.last), 32'(rsp.last));
        end
      end
      if (req.valid && req.ready)
        predict_request(req.req_type, req.proc_id, req.new_state);
    end
    outstanding <= expected_rsp.size();
    fail_count  <= mismatches;
    rsp_checked <= checked_n;
  end

endmodule

// ----- verif/job_slot_table_tb.sv -----
`timescale 1ns / 100ps
module job_slot_table_tb;
  import jst_pkg::*;

  localparam int POOL_N = 24;
  localparam int RANDOM_REQS = 180;

  logic clk;
  logic rst_n;

  jst_req_if req_ch ();
  jst_rsp_if rsp_ch ();

  int fail_count;
  int outstanding;
  int rsp_checked;

  int sent;          // every request accepted
  int useful_sent;   // requests of a known kind
  int burst_left;    // requests left in the current sender burst
  logic [9:0] rdy_cycle;

  // small pool of process ids so adds, lookups and removes hit each other
  logic [PID_W-1:0] pid_pool [POOL_N];

  job_slot_table dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  jst_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .rsp_checked (rsp_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver: cycles through always ready, coin flip, one in four, and rare
  always @(posedge clk) begin
    if (!rst_n) begin
      rdy_cycle     <= '0;
      rsp_ch.ready <= 1'b0;
    end else begin
      rdy_cycle <= rdy_cycle + 1'b1;
      case (rdy_cycle[8:7])
        2'd0: rsp_ch.ready <= 1'b1;
        2'd1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: rsp_ch.ready <= (rdy_cycle[1:0] == 2'd0);
        default: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // hard stop in case the block hangs or a result goes missing
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // one request per call; bursts of back-to-back requests with random gaps
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [PID_W-1:0] pid,
                          input logic [STATE_W-1:0] nst);
    int gap;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.proc_id   <= pid;
    req_ch.new_state <= nst;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    if (kind <= REQ_LIST) useful_sent++;
  endtask

  // hold off the sender until every predicted result has been taken
  task automatic wait_all_answered();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [PID_W-1:0] pick_pid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 12) return PID_W'($urandom);
    return pid_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  // mostly foreground so listings have something to report
  function automatic logic [STATE_W-1:0] pick_state();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return JS_UNDEF;
    if (r < 60) return JS_FG;
    if (r < 80) return JS_BG;
    return JS_STOP;
  endfunction

  initial begin
    int n;
    int r;
    logic [REQ_W-1:0] kind;
    rst_n = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_ADD;
    req_ch.proc_id   = '0;
    req_ch.new_state = JS_UNDEF;
    sent = 0;
    useful_sent = 0;
    burst_left = 0;
    pid_pool[0] = PID_W'(1);
    pid_pool[1] = '1;
    pid_pool[2] = 22'h2AAAAA;
    pid_pool[3] = 22'h155555;
    for (int i = 4; i < POOL_N; i++) pid_pool[i] = PID_W'($urandom_range(1, 22'h3FFFFF));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // listing an empty table gives the not-found request result
    send_req(REQ_LIST, '0, JS_UNDEF);
    // zero process id is refused by every keyed request
    send_req(REQ_ADD, '0, JS_FG);
    send_req(REQ_REMOVE, '0, JS_UNDEF);
    send_req(REQ_LOOKUP, '0, JS_UNDEF);
    send_req(REQ_STOP, '0, JS_UNDEF);
    // extreme pids, every state, state zero stored as given, duplicate pid
    send_req(REQ_ADD, '1, JS_FG);
    send_req(REQ_ADD, PID_W'(1), JS_BG);
    send_req(REQ_ADD, 22'h2AAAAA, JS_STOP);
    send_req(REQ_ADD, 22'h155555, JS_UNDEF);
    send_req(REQ_ADD, PID_W'(1), JS_FG);
    // lookups hit the lowest matching slot, plus one miss
    send_req(REQ_LOOKUP, PID_W'(1), JS_UNDEF);
    send_req(REQ_LOOKUP, '1, JS_UNDEF);
    send_req(REQ_LOOKUP, 22'h155555, JS_UNDEF);
    send_req(REQ_LOOKUP, 22'h000777, JS_UNDEF);
    // stop on a present entry, then on a missing one
    send_req(REQ_STOP, PID_W'(1), JS_UNDEF);
    send_req(REQ_STOP, 22'h000778, JS_UNDEF);
    send_req(REQ_LIST, '0, JS_UNDEF);
    // remove the first duplicate, the second one then shows up
    send_req(REQ_REMOVE, PID_W'(1), JS_UNDEF);
    send_req(REQ_LOOKUP, PID_W'(1), JS_UNDEF);
    send_req(REQ_REMOVE, 22'h000779, JS_UNDEF);
    // unknown request kinds
    for (int k = int'(REQ_LIST) + 1; k < 2 ** REQ_W; k++)
      send_req(REQ_W'(k), PID_W'(1), JS_FG);

    wait_all_answered();

    // random part built from short request sequences
    while (useful_sent < RANDOM_REQS) begin
      r = $urandom_range(0, 9);
      if (r <= 2) begin
        // fill run, often to a full table, then list the foreground jobs
        n = $urandom_range(6, 18);
        repeat (n) send_req(REQ_ADD, pick_pid(), pick_state());
        send_req(REQ_LIST, pick_pid(), pick_state());
      end else if (r <= 4) begin
        // drain run, each removal followed now and then by a lookup
        n = $urandom_range(4, 12);
        repeat (n) begin
          send_req(REQ_REMOVE, pick_pid(), pick_state());
          if ($urandom_range(0, 2) == 0) send_req(REQ_LOOKUP, pick_pid(), pick_state());
        end
      end else if (r <= 7) begin
        // mixed traffic on the pid pool
        n = $urandom_range(4, 12);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 30) kind = REQ_ADD;
          else if (r < 50) kind = REQ_REMOVE;
          else if (r < 65) kind = REQ_LOOKUP;
          else if (r < 80) kind = REQ_STOP;
          else kind = REQ_LIST;
          send_req(kind, pick_pid(), pick_state());
        end
      end else if (r == 8) begin
        // noise: any kind, any pid, any state
        n = $urandom_range(1, 4);
        repeat (n) send_req(REQ_W'($urandom_range(0, 2 ** REQ_W - 1)), PID_W'($urandom),
                            STATE_W'($urandom_range(0, 3)));
      end else begin
        wait_all_answered();
        send_req(REQ_LIST, pick_pid(), pick_state());
      end
    end

    wait_all_answered();
    // room for any stray result after the last expected one
    repeat (80) @(posedge clk);

    $display("covered %0d requests (add, remove, lookup, stop, list, unknown kinds)", sent);
    $display("with %0d results checked under sender gaps and receiver stalls", rsp_checked);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- job_slot_table.f -----
+incdir+src
src/jst_pkg.sv
src/jst_if.sv
src/jst_datapath.sv
src/jst_ctrl.sv
src/job_slot_table.sv
src/jst_checker.sv
verif/jst_checker.sv
verif/job_slot_table_tb.sv
